### design/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared widths, codes and controller/datapath handshake types for the
// sliding boxcar demean block.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int VALUE_W    = 17;
  localparam int STATUS_W   = 2;
  localparam int SUM_W      = 24;
  localparam int CNT_W      = 7;
  localparam int HIST_AW    = 7;
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam int POS_W      = 32;
  localparam int WIN_W      = 7;
  localparam int HALF_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // divider retires DIV_BITS quotient bits per cycle
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = SUM_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(7);
  localparam logic [POS_W-1:0] LEN_RESET = POS_W'(1024);
  localparam logic [POS_W-1:0] LEN_MIN   = POS_W'(3);

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WIN   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES = 1'b1;

  typedef struct packed {
    logic accept;     // good item taken: latch sample, write history
    logic rd_tail;    // read the sample leaving the window
    logic update;     // running sum / count update
    logic rd_centre;  // read centre sample, start divide
    logic emit;       // load a normal result
    logic emit_err;   // load a status result
    logic rd_flush;   // read sample dropping out during flush
    logic sub_flush;  // subtract it from the sum
  } sbd_cmd_t;

  typedef struct packed {
    logic cfg_bad;
    logic at_end;
    logic early;
    logic flush;
    logic last_pos;
    logic flush_sub;
    logic out_free;
    logic div_done;
  } sbd_stat_t;

endpackage

### design/sbd_div.sv
// ----------------------------------------------------------------------------
// sbd_div
// Signed-by-unsigned restoring divider, truncating toward zero, several
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module sbd_div import sbd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic        [CNT_W-1:0] divisor,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);

  logic [SUM_W-1:0]     shq_r, shq_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     dsr_r;
  logic                 neg_r;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    logic [CNT_W:0] t;
    shq_nxt = shq_r;
    rem_nxt = rem_r;
    for (int s = 0; s < DIV_BITS; s++) begin
      t = {rem_nxt, shq_nxt[SUM_W-1]};
      if (t >= {1'b0, dsr_r}) begin
        t       = t - {1'b0, dsr_r};
        shq_nxt = {shq_nxt[SUM_W-2:0], 1'b1};
      end else begin
        shq_nxt = {shq_nxt[SUM_W-2:0], 1'b0};
      end
      rem_nxt = t[CNT_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shq_r <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
      neg_r <= dividend[SUM_W-1];
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      shq_r <= shq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~shq_r + SUM_W'(1)) : shq_r;

endmodule

### design/sbd_dp.sv
// ----------------------------------------------------------------------------
// sbd_dp
// Datapath: config registers, sample history, running sum, flush pointer,
// divider and output register.
// ----------------------------------------------------------------------------
module sbd_dp import sbd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sbd_cmd_t                   cmd,
  output sbd_stat_t                  stat,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       cfg_valid,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VALUE_W-1:0]  out_value,
  output logic        [STATUS_W-1:0] out_status,
  output logic                       out_last_of_run,
  output logic                       out_series_end
);

  logic [WIN_W-1:0] win_r;
  logic [POS_W-1:0] len_r;

  logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
  logic signed [SAMPLE_W-1:0] hist_rd_r;
  logic        [HIST_AW-1:0]  rd_addr;
  logic                       rd_en;

  logic signed [SAMPLE_W-1:0] x_r;
  logic        [POS_W-1:0]    k_r;
  logic        [POS_W-1:0]    count_r;
  logic        [HALF_W-1:0]   h_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic        [CNT_W-1:0]    wc_r;
  logic        [POS_W-1:0]    i_r;
  logic                       flush_r;

  logic                       out_valid_r;
  logic signed [VALUE_W-1:0]  out_value_r;
  logic        [STATUS_W-1:0] out_status_r;
  logic                       out_last_r;
  logic                       out_end_r;

  logic                       short_len;
  logic                       win_over;
  logic [STATUS_W-1:0]        bad_code;
  logic [HALF_W-1:0]          h_new;
  logic [POS_W-1:0]           h_pos;
  logic                       tail_sub;
  logic [HIST_AW-1:0]         tail_addr;
  logic [HIST_AW-1:0]         flush_addr;
  logic [POS_W-1:0]           i_start;
  logic [POS_W-1:0]           lo;
  logic [CNT_W-1:0]           cnt_flush;
  logic                       div_done;
  logic signed [SUM_W-1:0]    div_q;
  logic signed [SUM_W-1:0]    sum_upd;
  logic                       out_free;
  logic                       out_load;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_RESET;
      len_r <= LEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW: win_r <= cfg_data[WIN_W-1:0];
        CFG_SERIES: len_r <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign short_len = len_r < LEN_MIN;
  assign win_over  = POS_W'(win_r) > len_r;
  assign bad_code  = short_len ? ST_SHORT : ST_WIN;

  // even window equal to an even series length gets h = len/2 - 1
  assign h_new = (POS_W'(win_r) == len_r && !len_r[0]) ? (len_r[HALF_W:1] - HALF_W'(1))
                                                        : win_r[WIN_W-1:1];

  assign h_pos      = POS_W'(h_r);
  assign tail_sub   = k_r >= POS_W'({h_r, 1'b1});
  assign tail_addr  = k_r[HIST_AW-1:0] - {h_r, 1'b1};
  assign flush_addr = i_r[HIST_AW-1:0] - HIST_AW'(h_r) - HIST_AW'(1);
  assign i_start    = (k_r >= h_pos) ? (k_r - h_pos) : '0;
  assign lo         = (i_r >= h_pos) ? (i_r - h_pos) : '0;
  // clipped count never exceeds the window, so the low bits are exact
  assign cnt_flush  = k_r[CNT_W-1:0] - lo[CNT_W-1:0] + CNT_W'(1);

  assign sum_upd = sum_r + SUM_W'(x_r) - (tail_sub ? SUM_W'(hist_rd_r) : SUM_W'(0));

  // history memory
  assign rd_en = cmd.rd_tail | cmd.rd_centre | cmd.rd_flush;
  always_comb begin
    priority if (cmd.rd_tail)  rd_addr = tail_addr;
    else if     (cmd.rd_flush) rd_addr = flush_addr;
    else                       rd_addr = i_r[HIST_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hist_mem[count_r[HIST_AW-1:0]] <= in_sample;
    end
    if (rd_en) begin
      hist_rd_r <= hist_mem[rd_addr];
    end
  end

  sbd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rd_centre),
    .dividend (sum_r),
    .divisor  (flush_r ? cnt_flush : wc_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // series state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      flush_r <= 1'b0;
      h_r     <= '0;
      sum_r   <= '0;
      wc_r    <= '0;
    end else begin
      if (cmd.accept && count_r == '0) begin
        h_r   <= h_new;
        sum_r <= '0;
        wc_r  <= '0;
      end
      if (cmd.update) begin
        sum_r   <= sum_upd;
        wc_r    <= wc_r + CNT_W'(!tail_sub);
        flush_r <= stat.at_end;
        if (!stat.at_end) begin
          count_r <= k_r + POS_W'(1);
        end
      end
      if (cmd.sub_flush) begin
        sum_r <= sum_r - SUM_W'(hist_rd_r);
      end
      if (cmd.emit && flush_r && stat.last_pos) begin
        count_r <= '0;
        flush_r <= 1'b0;
        sum_r   <= '0;
        wc_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r <= in_sample;
      k_r <= count_r;
    end
    if (cmd.update) begin
      i_r <= i_start;
    end else if (cmd.emit && flush_r && !stat.last_pos) begin
      i_r <= i_r + POS_W'(1);
    end
  end

  // output register
  assign out_free = !out_valid_r || out_ready;
  assign out_load = cmd.emit | cmd.emit_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_value_r  <= '0;
      out_status_r <= bad_code;
      out_last_r   <= 1'b1;
      out_end_r    <= 1'b0;
    end else if (cmd.emit) begin
      out_value_r  <= VALUE_W'(hist_rd_r) - div_q[VALUE_W-1:0];
      out_status_r <= ST_OK;
      out_last_r   <= !flush_r || stat.last_pos;
      out_end_r    <= flush_r && stat.last_pos;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_status      = out_status_r;
  assign out_last_of_run = out_last_r;
  assign out_series_end  = out_end_r;

  assign stat.cfg_bad   = short_len | win_over;
  assign stat.at_end    = k_r >= (len_r - POS_W'(1));
  assign stat.early     = k_r < h_pos;
  assign stat.flush     = flush_r;
  assign stat.last_pos  = i_r == k_r;
  assign stat.flush_sub = i_r >= h_pos;
  assign stat.out_free  = out_free;
  assign stat.div_done  = div_done;

endmodule

### design/sbd_ctrl.sv
// ----------------------------------------------------------------------------
// sbd_ctrl
// Sequencer: steps each item through history read, sum update, centre read,
// divide and result load, and walks the flush at the end of a series.
// ----------------------------------------------------------------------------
module sbd_ctrl import sbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sbd_stat_t stat,
  output sbd_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_TAIL = 4'd2;
  localparam logic [3:0] S_UPD  = 4'd3;
  localparam logic [3:0] S_CTR  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_EMIT = 4'd6;
  localparam logic [3:0] S_FRD  = 4'd7;
  localparam logic [3:0] S_FSUB = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = state_r == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.cfg_bad) begin
            state_nxt = S_ERR;
          end else begin
            cmd.accept = 1'b1;
            state_nxt  = S_TAIL;
          end
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_TAIL: begin
        cmd.rd_tail = 1'b1;
        state_nxt   = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        // before h+1 samples of a series there is nothing to show
        if (!stat.at_end && stat.early) state_nxt = S_IDLE;
        else                            state_nxt = S_CTR;
      end
      S_CTR: begin
        cmd.rd_centre = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!stat.flush || stat.last_pos) state_nxt = S_IDLE;
          else if (stat.flush_sub)          state_nxt = S_FRD;
          else                              state_nxt = S_CTR;
        end
      end
      S_FRD: begin
        cmd.rd_flush = 1'b1;
        state_nxt    = S_FSUB;
      end
      S_FSUB: begin
        cmd.sub_flush = 1'b1;
        state_nxt     = S_CTR;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/sliding_boxcar_demean.sv
// ----------------------------------------------------------------------------
// sliding_boxcar_demean
// Streaming moving-average subtraction: each result is a centred sample less
// the mean of a clipped odd window around it.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | in_sample (16 b signed)
//  out_    | output    | out_valid / out_ready | out_value, out_status,
//          |           |                       | out_last_of_run, out_series_end
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time. A sample that gives no result is accepted, reads the tail
// and updates the sum; one giving a result adds a centre read, the divide (4
// quotient bits a cycle over a 24-bit sum) and the load. A series-end flush
// repeats these per extra result, first subtracting any sample that drops out.
// A bad configuration gets a status result per item. The output register lets
// the next item in while a result waits; a stalled output holds the sequencer
// at its load step. Reset is synchronous; the history memory needs no clearing.
// ----------------------------------------------------------------------------
module sliding_boxcar_demean import sbd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VALUE_W-1:0]   out_value,
  output logic        [STATUS_W-1:0]  out_status,
  output logic                        out_last_of_run,
  output logic                        out_series_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  sbd_cmd_t  cmd;
  sbd_stat_t stat;

  assign cfg_ready = 1'b1;

  sbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_sample       (in_sample),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run),
    .out_series_end  (out_series_end)
  );

endmodule
